FILE: design/csbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csbd_pkg;

    // LED colour codes, RGB bits: red in bit 2, green in bit 1, blue in bit 0
    typedef enum logic [2:0] {
        COL_DARK    = 3'd0,
        COL_BLUE    = 3'd1,
        COL_GREEN   = 3'd2,
        COL_CYAN    = 3'd3,
        COL_RED     = 3'd4,
        COL_MAGENTA = 3'd5,
        COL_YELLOW  = 3'd6,
        COL_WHITE   = 3'd7
    } t_colour;

    typedef enum logic [1:0] {
        ST_BYTE_OK     = 2'd0,
        ST_BAD_COUNT   = 2'd1,
        ST_BAD_COLOUR  = 2'd2,
        ST_END         = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PAR_NONE = 2'd0,
        PAR_EVEN = 2'd1,
        PAR_ODD  = 2'd2,
        PAR_RSVD = 2'd3
    } t_parity_mode;

    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_W'(5);

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  acc;
    } t_state;

    typedef struct packed {
        t_status            status;
        logic               parity_ok;
        logic               mark_parity;
        logic [BYTE_W-1:0]  data_byte;
    } t_result;

endpackage

`default_nettype wire

FILE: design/csbd_step.sv
`timescale 1ns / 1ps
`default_nettype none

module csbd_step (
    input  wire csbd_pkg::t_state       i_state,
    input  wire logic [2:0]             i_colour,
    input  wire logic                   i_stream_end,
    input  wire csbd_pkg::t_parity_mode i_parity_mode,
    output csbd_pkg::t_state            o_state,
    output logic                        o_emit,
    output csbd_pkg::t_result           o_result
);
    import csbd_pkg::*;

    logic [1:0] w_bits;
    logic       w_mark;
    logic       w_par;
    logic       w_expected;

    // blue 00, magenta 01, yellow 10, white 11
    assign w_bits = {i_colour[1], i_colour[2] & i_colour[0]};
    assign w_mark = i_colour[2];
    assign w_par  = ^i_state.acc;

    always_comb begin
        unique case (i_parity_mode)
            PAR_ODD:  w_expected = ~w_par;
            PAR_EVEN: w_expected = w_par;
            default:  w_expected = 1'b1;
        endcase
    end

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '{status: ST_BYTE_OK, parity_ok: 1'b0, mark_parity: 1'b0,
                     data_byte: '0};
        if (i_stream_end) begin
            o_emit          = 1'b1;
            o_result.status = ST_END;
        end else begin
            unique case (t_colour'(i_colour))
                COL_DARK: begin
                end
                COL_BLUE, COL_MAGENTA, COL_YELLOW, COL_WHITE: begin
                    o_state.acc = {i_state.acc[BYTE_W-3:0], w_bits};
                    if (i_state.count < COUNT_SAT) begin
                        o_state.count = i_state.count + COUNT_W'(1);
                    end
                end
                COL_GREEN, COL_RED: begin
                    o_emit = 1'b1;
                    if (i_state.count == COUNT_FULL) begin
                        o_result.data_byte   = i_state.acc;
                        o_result.mark_parity = w_mark;
                        o_result.parity_ok   = (w_expected == w_mark);
                    end else begin
                        o_result.status = ST_BAD_COUNT;
                    end
                end
                default: begin
                    o_emit          = 1'b1;
                    o_result.status = ST_BAD_COLOUR;
                end
            endcase
        end
        // every result starts a new byte
        if (o_emit) begin
            o_state = '0;
        end
    end

endmodule

`default_nettype wire

FILE: design/colour_symbol_byte_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Colour-symbol byte decoder.
// Input stream (s_axis): one LED colour per transaction in tdata[2:0];
// tlast marks end of stream, in which case the colour is ignored and an
// end status comes out. Dark symbols produce nothing, the four data colours
// shift two bits each into the byte, a green or red mark closes the byte.
// Output stream (m_axis): at most one result per input transaction, carrying
// the byte, the mark parity bit, the parity check and a status code.
// Config channel: i_cfg_data sets the parity mode (0 none, 1 even, 2 odd);
// write it only while the block is idle. It is always ready.
// The input register loads when a transaction is accepted and the result
// register when the decoded item moves on into it. Throughput: one
// transaction per cycle while the receiver keeps up, set by the
// combinational decode between the two register stages.
// Reset (synchronous, active low) empties both stages, clears the symbol
// count and accumulator and sets the parity mode to odd.
// When the receiver stalls, the result register holds; the input register
// still takes one more transaction, then s_axis_tready drops until the
// result register drains.

module colour_symbol_byte_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,      // parity_mode
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [2:0] colour, [7:3] zero
    input  wire logic        s_axis_tlast,    // stream_end
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,    // [7:0] data_byte, [8] mark_parity,
                                              // [9] parity_ok, [15:10] zero
    output logic [1:0]       m_axis_tuser     // status
);
    import csbd_pkg::*;

    // config register
    t_parity_mode r_parity_mode;

    // input stage
    logic         r_in_valid;
    logic [2:0]   r_in_colour;
    logic         r_in_end;

    // decoder state and result stage
    t_state       r_state;
    t_state       n_state;
    logic         r_out_valid;
    t_result      r_out;
    t_result      n_out;
    logic         w_emit;
    logic         w_out_free;
    logic         w_advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_mode <= PAR_ODD;
        end else if (i_cfg_valid) begin
            r_parity_mode <= t_parity_mode'(i_cfg_data);
        end
    end

    // The result register can take a new value when empty or being drained.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Hold the accepted symbol until the result stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_colour <= s_axis_tdata[2:0];
            r_in_end    <= s_axis_tlast;
        end
    end

    csbd_step u_step (
        .i_state       (r_state),
        .i_colour      (r_in_colour),
        .i_stream_end  (r_in_end),
        .i_parity_mode (r_parity_mode),
        .o_state       (n_state),
        .o_emit        (w_emit),
        .o_result      (n_out)
    );

    // Advance the symbol state only as the item moves into the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Load a result when one is produced; drop valid once the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out.parity_ok, r_out.mark_parity, r_out.data_byte};
    assign m_axis_tuser  = r_out.status;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import csbd_pkg::*;

    // One directed stimulus row: the symbol to send and, where the answer is
    // obvious, the result typed in by hand.
    typedef struct packed {
        t_colour col;
        logic    eos;
        logic    typed;
        logic    has_res;
        t_result res;
    } t_row;

    localparam int N_DIRECTED    = 25;
    localparam int N_PHASES      = 5;
    localparam int PHASE_ITEMS   = 130;
    localparam int IDLE_PCT      = 29;
    localparam int DRAIN_CYCLES  = 4;

    localparam t_colour DATA_COLOURS [4] = '{COL_BLUE, COL_MAGENTA, COL_YELLOW, COL_WHITE};
    localparam t_parity_mode PHASE_MODES [N_PHASES] =
        '{PAR_NONE, PAR_EVEN, PAR_RSVD, PAR_ODD, PAR_EVEN};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;

    logic        o_cfg_ready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Shadow of the decoder state, advanced on every accepted transaction
    logic [COUNT_W-1:0] sym_count = '0;
    logic [BYTE_W-1:0]  byte_acc = '0;
    t_parity_mode       parity_mode = PAR_ODD;

    t_result pending_results [$];
    t_row    directed_rows [N_DIRECTED];
    int      items_sent = 0;
    int      errors = 0;
    int      results_by_status [4] = '{0, 0, 0, 0};
    bit      no_idle = 1'b0;

    colour_symbol_byte_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),        // [2:0] colour, [7:3] zero
        .s_axis_tlast  (s_tlast),        // stream_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte, [8] mark_parity,
                                         // [9] parity_ok, [15:10] zero
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Advance the shadow state by one symbol; return 1 when the symbol yields
    // a result, which is then placed in res.
    function automatic logic decode_symbol(input t_colour col, input logic eos,
                                           output t_result res);
        logic       p;
        logic       want_mark;
        logic [1:0] pair;
        res = '0;
        if (eos) begin
            // end of stream wins over whatever color rides along
            res.status = ST_END;
        end else begin
            case (col)
                COL_DARK: begin
                    return 1'b0;
                end
                COL_BLUE, COL_MAGENTA, COL_YELLOW, COL_WHITE: begin
                    case (col)
                        COL_BLUE:    pair = 2'b00;
                        COL_MAGENTA: pair = 2'b01;
                        COL_YELLOW:  pair = 2'b10;
                        default:     pair = 2'b11;
                    endcase
                    // older pairs fall off the top once more than four arrive
                    byte_acc = {byte_acc[BYTE_W-3:0], pair};
                    if (sym_count < COUNT_SAT)
                        sym_count = sym_count + 1'b1;
                    return 1'b0;
                end
                COL_GREEN, COL_RED: begin
                    if (sym_count == COUNT_FULL) begin
                        p = ^byte_acc;
                        case (parity_mode)
                            PAR_ODD:  want_mark = ~p;
                            PAR_EVEN: want_mark = p;
                            default:  want_mark = 1'b1;   // none and reserved: red only
                        endcase
                        res.data_byte   = byte_acc;
                        res.mark_parity = (col == COL_RED);
                        res.parity_ok   = (res.mark_parity == want_mark);
                        res.status      = ST_BYTE_OK;
                    end else begin
                        res.status = ST_BAD_COUNT;
                    end
                end
                default: begin
                    res.status = ST_BAD_COLOUR;
                end
            endcase
        end
        // every result starts a fresh byte
        sym_count = '0;
        byte_acc  = '0;
        return 1'b1;
    endfunction

    function automatic t_row typed_row(input t_colour col, input logic eos, input logic has,
                                       input t_status st, input logic ok, input logic mark,
                                       input logic [7:0] data);
        t_row r;
        r.col               = col;
        r.eos               = eos;
        r.typed             = 1'b1;
        r.has_res           = has;
        r.res.status        = st;
        r.res.parity_ok     = ok;
        r.res.mark_parity   = mark;
        r.res.data_byte     = data;
        return r;
    endfunction

    function automatic t_row pred_row(input t_colour col, input logic eos);
        t_row r;
        r       = '0;
        r.col   = col;
        r.eos   = eos;
        return r;
    endfunction

    // Present one symbol at the falling edge and hold it until the decoder
    // takes the transaction. Called and returns at a falling edge.
    task automatic send_item(input t_colour col, input logic eos, input logic use_given,
                             input logic given_has, input t_result given_res);
        t_result res;
        logic    has;
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'd0, col};
        s_tlast  = eos;
        do @(posedge i_clk); while (!s_axis_tready);
        has = decode_symbol(col, eos, res);
        if (use_given) begin
            has = given_has;
            res = given_res;
        end
        if (has)
            pending_results.push_back(res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random(input t_colour col, input logic eos);
        send_item(col, eos, 1'b0, 1'b0, '0);
    endtask

    // Hold off the sender until every expected result is out, then let the
    // pipeline settle so no dark or data symbol is still in flight.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_parity_mode(input t_parity_mode mode);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        parity_mode = mode;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed bytes (four data symbols, a few darks sprinkled in,
    // then a mark), the rest short/long runs before a mark and lone noise.
    task automatic run_random(input int n);
        int target;
        int pick;
        int n_data;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 84) begin
                n_data = (pick < 70) ? 4 : $urandom_range(7);
                for (int k = 0; k < n_data; k++) begin
                    if ($urandom_range(9) == 0)
                        send_random(COL_DARK, 1'b0);
                    send_random(DATA_COLOURS[$urandom_range(3)], 1'b0);
                end
                send_random($urandom_range(1) ? COL_RED : COL_GREEN, 1'b0);
            end else begin
                send_random(t_colour'($urandom_range(7)), ($urandom_range(3) == 0));
            end
        end
    endtask

    // Receiver: drop tready at random, except during the no-idle stretch
    always @(negedge i_clk) begin
        m_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            got.data_byte   = m_axis_tdata[7:0];
            got.mark_parity = m_axis_tdata[8];
            got.parity_ok   = m_axis_tdata[9];
            got.status      = t_status'(m_axis_tuser);
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: byte %02h mark %0b ok %0b status %0d",
                         $time, got.data_byte, got.mark_parity, got.parity_ok, got.status);
            end else begin
                want = pending_results.pop_front();
                results_by_status[want.status]++;
                if (got.data_byte !== want.data_byte) begin
                    errors++;
                    $display("%0t: data_byte expected %02h actual %02h",
                             $time, want.data_byte, got.data_byte);
                end
                if (got.mark_parity !== want.mark_parity) begin
                    errors++;
                    $display("%0t: mark_parity expected %0b actual %0b",
                             $time, want.mark_parity, got.mark_parity);
                end
                if (got.parity_ok !== want.parity_ok) begin
                    errors++;
                    $display("%0t: parity_ok expected %0b actual %0b",
                             $time, want.parity_ok, got.parity_ok);
                end
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                end
            end
        end
    end

    initial begin
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        directed_rows = '{
            // end of stream straight after reset, color ignored
            typed_row(COL_WHITE,   1'b1, 1'b1, ST_END,        1'b0, 1'b0, 8'h00),
            // mark with no data before it
            typed_row(COL_RED,     1'b0, 1'b1, ST_BAD_COUNT,  1'b0, 1'b0, 8'h00),
            typed_row(COL_CYAN,    1'b0, 1'b1, ST_BAD_COLOUR, 1'b0, 1'b0, 8'h00),
            // all-ones byte, red mark passes in odd mode
            pred_row(COL_WHITE, 1'b0), pred_row(COL_WHITE, 1'b0),
            pred_row(COL_WHITE, 1'b0), pred_row(COL_WHITE, 1'b0),
            typed_row(COL_RED,     1'b0, 1'b1, ST_BYTE_OK,    1'b1, 1'b1, 8'hFF),
            // all-zeros byte, green mark fails in odd mode
            pred_row(COL_BLUE, 1'b0), pred_row(COL_BLUE, 1'b0),
            pred_row(COL_BLUE, 1'b0), pred_row(COL_BLUE, 1'b0),
            typed_row(COL_GREEN,   1'b0, 1'b1, ST_BYTE_OK,    1'b0, 1'b0, 8'h00),
            // mixed byte with a dark separator in the middle
            pred_row(COL_MAGENTA, 1'b0), pred_row(COL_YELLOW, 1'b0),
            pred_row(COL_DARK, 1'b0),    pred_row(COL_WHITE, 1'b0),
            pred_row(COL_BLUE, 1'b0),    pred_row(COL_GREEN, 1'b0),
            // five data symbols: count saturates, mark reports a bad count
            pred_row(COL_MAGENTA, 1'b0), pred_row(COL_YELLOW, 1'b0),
            pred_row(COL_WHITE, 1'b0),   pred_row(COL_BLUE, 1'b0),
            pred_row(COL_MAGENTA, 1'b0),
            typed_row(COL_RED,     1'b0, 1'b1, ST_BAD_COUNT,  1'b0, 1'b0, 8'h00)
        };

        // Hold reset, then release it at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part runs in the reset parity mode (odd)
        foreach (directed_rows[i])
            send_item(directed_rows[i].col, directed_rows[i].eos, directed_rows[i].typed,
                      directed_rows[i].has_res, directed_rows[i].res);

        // Random part: one phase per parity setting, with even run twice; the middle
        // phase (reserved) without any idling on either side
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_parity_mode(PHASE_MODES[ph]);
            no_idle = (ph == 2);
            run_random(PHASE_ITEMS);
        end
        no_idle = 1'b0;

        // Let the tail drain, then flag anything still outstanding
        s_tvalid = 1'b0;
        for (int k = 0; k < 500 && pending_results.size() != 0; k++)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            errors += pending_results.size();
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end

        $display("Sent %0d symbol transactions over %0d parity phases (none, even, odd, reserved).",
                 items_sent, N_PHASES + 1);
        $display("Checked results: %0d bytes, %0d bad counts, %0d bad colors, %0d end markers.",
                 results_by_status[ST_BYTE_OK], results_by_status[ST_BAD_COUNT],
                 results_by_status[ST_BAD_COLOUR], results_by_status[ST_END]);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
